// ===== hw/rtl/ldme_pkg.sv =====
`timescale 1ns / 1ps
package ldme_pkg;

  // Lattice edge length; a power of two so that periodic wrap is the
  // natural overflow of each coordinate field.
  localparam int SIDE = 16;
  localparam int CW   = $clog2(SIDE);
  localparam int AW   = 3 * CW;
  localparam int VOL  = SIDE * SIDE * SIDE;

  typedef logic [AW-1:0] addr_t;
  typedef logic [2:0]    word_t;

  localparam word_t EMPTY = 3'd6;

  localparam logic [2:0] OP_BIRTH = 3'd0;
  localparam logic [2:0] OP_TRANS = 3'd1;
  localparam logic [2:0] OP_CUBE  = 3'd2;
  localparam logic [2:0] OP_SWAP  = 3'd3;
  localparam logic [2:0] OP_WRITE = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  typedef struct packed {
    logic [2:0]  op;
    logic [11:0] site;
    logic [2:0]  dir;
    logic [3:0]  mask;
    logic        test_only;
    logic [2:0]  write_word;
  } req_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] read_word;
  } res_t;

endpackage

// ===== hw/rtl/lattice_dimer_move_engine.sv =====
`timescale 1ns / 1ps
// Sequence: write and read go straight to the RAM; out-of-range or bad requests are answered from idle;
// birth checks that both ends are empty; translate fetches p, its partner q and the targets; swap and
// cube read the eight cube words, decide, check up to 56 sites, and write 8 words if kept.
// Throughput: one transaction at a time; busy, if raised, stays high until its result strobes.
// Reset: synchronous; after rst the block clears all 4096 sites to empty, one per cycle,
// with busy high. The receiver cannot stall.
module lattice_dimer_move_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ldme_pkg::req_t req,
  output logic           done,
  output ldme_pkg::res_t result
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_B0, S_B1, S_B2, S_T0, S_T1, S_T2, S_T3, S_T4,
    S_SR, S_SD, S_CA, S_CB, S_CC, S_RD0, S_RD1, S_WR
  } state_t;

  state_t state;

  ldme_pkg::req_t  rq;
  ldme_pkg::addr_t cor [8];
  ldme_pkg::word_t nw  [8];
  ldme_pkg::word_t old [8];
  ldme_pkg::word_t tmp, wexp;
  ldme_pkg::addr_t chk_addr;
  ldme_pkg::addr_t clr_cnt;
  logic [3:0]      rcnt;
  logic [2:0]      bi, ki, widx, wlast;

  ldme_pkg::addr_t sa, sa_in, rd_addr, nbr_p, nbr_q;
  ldme_pkg::word_t nbr_d, rdata, ov_word, wdata;
  ldme_pkg::addr_t waddr;
  logic            we;

  ldme_pkg::word_t sw_new [8];
  logic            sw_changed, cube_ok;

  assign sa    = ldme_pkg::AW'(rq.site);
  assign sa_in = ldme_pkg::AW'(req.site);
  assign busy  = (state != S_IDLE);

  // Corner b of the cube at anchor a: +b[2] on x, +b[1] on y, +b[0] on z.
  function automatic ldme_pkg::addr_t corner(ldme_pkg::addr_t a, logic [2:0] b);
    logic [ldme_pkg::CW-1:0] x, y, z;
    x = a[3*ldme_pkg::CW-1:2*ldme_pkg::CW] + ldme_pkg::CW'(b[2]);
    y = a[2*ldme_pkg::CW-1:ldme_pkg::CW] + ldme_pkg::CW'(b[1]);
    z = a[ldme_pkg::CW-1:0] + ldme_pkg::CW'(b[0]);
    return {x, y, z};
  endfunction

  ldme_nbr u_nbr (
    .p(nbr_p),
    .d(nbr_d),
    .q(nbr_q)
  );

  ldme_ram #(
    .WIDTH(3),
    .DEPTH(ldme_pkg::VOL)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  // Steer the shared neighbor unit by sequencer step.
  always_comb begin
    nbr_p = sa;
    nbr_d = rq.dir;
    case (state)
      S_B1: nbr_d = {rq.dir[1:0], 1'b0};
      S_T1: nbr_d = rdata;
      S_T3: nbr_p = cor[1];
      S_CA: begin
        nbr_p = cor[bi];
        nbr_d = ki - 3'd1;
      end
      S_CB: begin
        nbr_p = chk_addr;
        nbr_d = ov_word;
      end
      default: ;
    endcase
  end

  // Read address for the word that arrives in the next cycle.
  always_comb begin
    case (state)
      S_B0, S_T0, S_RD0:  rd_addr = sa;
      S_B1, S_T1, S_T2,
      S_T3, S_CB:         rd_addr = nbr_q;
      S_SR:               rd_addr = corner(sa, rcnt[2:0]);
      S_CA:               rd_addr = (ki == 3'd0) ? cor[bi] : nbr_q;
      default:            rd_addr = '0;
    endcase
  end

  // Write port: clearing sweep or the pending write list.
  always_comb begin
    we    = 1'b0;
    waddr = cor[widx];
    wdata = nw[widx];
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_cnt;
      wdata = ldme_pkg::EMPTY;
    end else if (state == S_WR) begin
      we = 1'b1;
    end
  end

  // During the check, cube sites read as their swapped words.
  always_comb begin
    ov_word = rdata;
    for (int b = 0; b < 8; b++) begin
      if (cor[b] == chk_addr) ov_word = nw[b];
    end
  end

  // Swap of paired sites across the cube along the chosen axis.
  always_comb begin
    logic [3:0] m;
    int         pos, c, ch;
    m          = (rq.op == ldme_pkg::OP_CUBE) ? 4'hF : rq.mask;
    pos        = 2 - int'(rq.dir[1:0]);
    sw_changed = 1'b0;
    for (int b = 0; b < 8; b++) sw_new[b] = old[b];
    for (int b = 0; b < 8; b++) begin
      c = b | (1 << pos);
      case (rq.dir[1:0])
        2'd0:    ch = b & 3;
        2'd1:    ch = ((b >> 1) & 2) | (b & 1);
        default: ch = (b >> 1) & 3;
      endcase
      if (((b >> pos) & 1) == 0 && m[ch]) begin
        sw_new[b] = old[c];
        sw_new[c] = old[b];
        if (old[b] != old[c]) sw_changed = 1'b1;
      end
    end
  end

  // Cube exchange is allowed only for the two aligned plaquette patterns.
  function automatic logic aligned(ldme_pkg::word_t o [8], int ax, int face, int dn);
    logic ok;
    ok = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (((b >> (2 - ax)) & 1) == face &&
          o[b] != 3'(2 * dn + ((b >> (2 - dn)) & 1))) ok = 1'b0;
    end
    return ok;
  endfunction

  // The two axes across the chosen one, in cyclic order.
  always_comb begin
    int ax, pa, qa;
    ax = int'(rq.dir[1:0]);
    case (ax)
      0: begin
        pa = 1;
        qa = 2;
      end
      1: begin
        pa = 2;
        qa = 0;
      end
      default: begin
        pa = 0;
        qa = 1;
      end
    endcase
    cube_ok = (aligned(old, ax, 0, pa) && aligned(old, ax, 1, qa)) ||
              (aligned(old, ax, 0, qa) && aligned(old, ax, 1, pa));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ldme_pkg::AW'(1);
          if (clr_cnt == ldme_pkg::AW'(ldme_pkg::VOL - 1)) state <= S_IDLE;
        end

        S_IDLE: begin
          if (start) begin
            rq               <= req;
            result.accepted  <= 1'b0;
            result.read_word <= 3'd0;
            if (int'(req.site) >= ldme_pkg::VOL) begin
              // Out-of-range site: reject, read reports empty.
              done <= 1'b1;
              if (req.op == ldme_pkg::OP_READ) result.read_word <= ldme_pkg::EMPTY;
            end else begin
              case (req.op)
                ldme_pkg::OP_BIRTH: begin
                  if (req.dir < 3'd3) state <= S_B0;
                  else done <= 1'b1;
                end
                ldme_pkg::OP_TRANS: begin
                  if (req.dir < 3'd6) state <= S_T0;
                  else done <= 1'b1;
                end
                ldme_pkg::OP_CUBE, ldme_pkg::OP_SWAP: begin
                  rcnt <= '0;
                  if (req.dir < 3'd3) state <= S_SR;
                  else done <= 1'b1;
                end
                ldme_pkg::OP_WRITE: begin
                  cor[0] <= sa_in;
                  nw[0]  <= (req.write_word > 3'd5) ? ldme_pkg::EMPTY : req.write_word;
                  widx   <= '0;
                  wlast  <= '0;
                  state  <= S_WR;
                end
                ldme_pkg::OP_READ: state <= S_RD0;
                default: done <= 1'b1;
              endcase
            end
          end
        end

        // Birth: both ends must be empty.
        S_B0: begin
          cor[0] <= sa;
          state  <= S_B1;
        end
        S_B1: begin
          tmp    <= rdata;
          cor[1] <= nbr_q;
          state  <= S_B2;
        end
        S_B2: begin
          nw[0] <= {rq.dir[1:0], 1'b0};
          nw[1] <= {rq.dir[1:0], 1'b1};
          if (tmp == ldme_pkg::EMPTY && rdata == ldme_pkg::EMPTY) begin
            if (rq.test_only) begin
              done            <= 1'b1;
              result.accepted <= 1'b1;
              state           <= S_IDLE;
            end else begin
              widx  <= '0;
              wlast <= 3'd1;
              state <= S_WR;
            end
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end

        // Translate: fetch p, partner q, then targets u and v.
        S_T0: begin
          cor[0] <= sa;
          state  <= S_T1;
        end
        S_T1: begin
          nw[2]  <= rdata;
          cor[1] <= nbr_q;
          if (rdata > 3'd5) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_T2;
          end
        end
        S_T2: begin
          nw[3]  <= rdata;
          cor[2] <= nbr_q;
          state  <= S_T3;
        end
        S_T3: begin
          tmp    <= rdata;
          cor[3] <= nbr_q;
          state  <= S_T4;
        end
        S_T4: begin
          nw[0] <= ldme_pkg::EMPTY;
          nw[1] <= ldme_pkg::EMPTY;
          if ((cor[2] == cor[0] || cor[2] == cor[1] || tmp == ldme_pkg::EMPTY) &&
              (cor[3] == cor[0] || cor[3] == cor[1] || rdata == ldme_pkg::EMPTY)) begin
            if (rq.test_only) begin
              done            <= 1'b1;
              result.accepted <= 1'b1;
              state           <= S_IDLE;
            end else begin
              widx  <= '0;
              wlast <= 3'd3;
              state <= S_WR;
            end
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end

        // Swap: stream the eight cube words in, one read per cycle.
        S_SR: begin
          if (rcnt != 4'd0) old[rcnt[2:0] - 3'd1] <= rdata;
          if (rcnt != 4'd8) cor[rcnt[2:0]] <= corner(sa, rcnt[2:0]);
          rcnt <= rcnt + 4'd1;
          if (rcnt == 4'd8) state <= S_SD;
        end
        S_SD: begin
          for (int b = 0; b < 8; b++) nw[b] <= sw_new[b];
          bi <= '0;
          ki <= '0;
          if (!sw_changed || (rq.op == ldme_pkg::OP_CUBE && !cube_ok)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_CA;
          end
        end
        // Check each cube site and its six neighbors against the swapped words.
        S_CA: begin
          chk_addr <= rd_addr;
          state    <= S_CB;
        end
        S_CB: begin
          if (ov_word == ldme_pkg::EMPTY) begin
            if (ki == 3'd6) begin
              ki <= '0;
              bi <= bi + 3'd1;
              if (bi == 3'd7) begin
                if (rq.test_only) begin
                  done            <= 1'b1;
                  result.accepted <= 1'b1;
                  state           <= S_IDLE;
                end else begin
                  widx  <= '0;
                  wlast <= 3'd7;
                  state <= S_WR;
                end
              end else begin
                state <= S_CA;
              end
            end else begin
              ki    <= ki + 3'd1;
              state <= S_CA;
            end
          end else if (ov_word > 3'd5) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            chk_addr <= nbr_q;
            wexp     <= ov_word ^ 3'd1;
            state    <= S_CC;
          end
        end
        S_CC: begin
          if (ov_word != wexp) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (ki == 3'd6) begin
            ki <= '0;
            bi <= bi + 3'd1;
            if (bi == 3'd7) begin
              if (rq.test_only) begin
                done            <= 1'b1;
                result.accepted <= 1'b1;
                state           <= S_IDLE;
              end else begin
                widx  <= '0;
                wlast <= 3'd7;
                state <= S_WR;
              end
            end else begin
              state <= S_CA;
            end
          end else begin
            ki    <= ki + 3'd1;
            state <= S_CA;
          end
        end

        S_RD0: state <= S_RD1;
        S_RD1: begin
          done             <= 1'b1;
          result.accepted  <= 1'b1;
          result.read_word <= rdata;
          state            <= S_IDLE;
        end

        // Drain the write list in order.
        S_WR: begin
          widx <= widx + 3'd1;
          if (widx == wlast) begin
            done            <= 1'b1;
            result.accepted <= 1'b1;
            state           <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !we) else $error("RAM write while idle");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");

  a_start_answered: assert property (@(posedge clk) disable iff (rst)
    (start && state == S_IDLE) |=> (done || busy)) else $error("transaction dropped");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (we && wdata == ldme_pkg::EMPTY))
    else $error("clear sweep writes wrong word");

endmodule

// ===== hw/rtl/ldme_ram.sv =====
`timescale 1ns / 1ps
module ldme_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ldme_nbr.sv =====
`timescale 1ns / 1ps
// Neighbor address unit: one step along direction d with periodic wrap.
module ldme_nbr (
  input  ldme_pkg::addr_t p,
  input  ldme_pkg::word_t d,
  output ldme_pkg::addr_t q
);

  logic [ldme_pkg::CW-1:0] x, y, z, step;
  logic [1:0]              axis;

  always_comb begin
    x    = p[3*ldme_pkg::CW-1:2*ldme_pkg::CW];
    y    = p[2*ldme_pkg::CW-1:ldme_pkg::CW];
    z    = p[ldme_pkg::CW-1:0];
    axis = (d[2:1] == 2'd3) ? 2'd0 : d[2:1];
    step = d[0] ? '1 : ldme_pkg::CW'(1);
    case (axis)
      2'd0:    x = x + step;
      2'd1:    y = y + step;
      default: z = z + step;
    endcase
    q = {x, y, z};
  end

endmodule
